// ===== rtl/dpsa_pkg.sv =====
// Shared types and constants for the dual pool slot allocator.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package dpsa_pkg;

    // Default pool size and width of the slot fields on the ports
    localparam int SLOTS_DEF = 64;
    localparam int SLOT_W    = 6;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Pool codes
    localparam logic POOL_TEX = 1'b0;
    localparam logic POOL_SHD = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/dual_pool_slot_allocator.sv =====
// Dual pool slot allocator: top level with the sequencer and hint registers.
// Depends on dpsa_pkg and dpsa_busy_ram.
//
//   channel  signals                        direction  payload
//   input    in_valid / in_stall            in         command, pool, slot
//   output   out_valid / out_stall          out        ok, granted_slot
//
// A free, or an allocate whose hinted slot is idle, passes from accept
// through ST_LOOK and ST_DONE to the next accept. When the hint misses,
// the search reads the busy store one slot per cycle from slot 0, up to
// the last slot. The single read port of the busy store sets this pace.
// After reset a clearing pass writes all 2 * 2**clog2(SLOTS) store entries
// (128 at 64 slots); no item is taken until it ends.
// A result waits in the output register while out_stall is high; the
// sequencer holds its finished item until that register frees up.
`timescale 1ns / 1ps

module dual_pool_slot_allocator #(
    parameter int SLOTS = dpsa_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic                        pool,
    input  logic [dpsa_pkg::SLOT_W-1:0] slot,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    output logic [dpsa_pkg::SLOT_W-1:0] granted_slot
);

    import dpsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int AW    = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Control state
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] tex_hint_reg, tex_hint_next;
    logic [IDX_W-1:0] shd_hint_reg, shd_hint_next;
    logic             out_valid_reg, out_valid_next;

    // Item payload and result
    logic             cmd_reg, cmd_next;
    logic             pool_reg, pool_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             range_reg, range_next;
    logic             res_ok_reg, res_ok_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic             ok_reg, ok_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;

    // Busy store port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    logic [IDX_W-1:0] in_hint;
    logic [IDX_W-1:0] cur_hint;
    logic [IDX_W-1:0] new_hint;
    logic             hint_we;

    dpsa_busy_ram #(
        .AW (AW)
    ) u_busy_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_hint  = (pool == POOL_SHD) ? shd_hint_reg : tex_hint_reg;
    assign cur_hint = (pool_reg == POOL_SHD) ? shd_hint_reg : tex_hint_reg;

    // Sequencer: next state, store accesses and result
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        pool_next      = pool_reg;
        slot_next      = slot_reg;
        range_next     = range_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        ok_next        = ok_reg;
        granted_next   = granted_reg;
        mem_we         = 1'b0;
        mem_waddr      = {pool_reg, slot_reg};
        mem_wdata      = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = {pool_reg, slot_reg};
        hint_we        = 1'b0;
        new_hint       = cur_hint;

        // Output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    pool_next  = pool;
                    slot_next  = IDX_W'(slot);
                    range_next = 32'(slot) < 32'(SLOTS);
                    mem_re     = 1'b1;
                    mem_raddr  = {pool, (command == CMD_ALLOC) ? in_hint : IDX_W'(slot)};
                    state_next = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    // Free: clear a busy slot and hint at it
                    res_slot_next = '0;
                    res_ok_next   = 1'b0;
                    if (range_reg && mem_rdata)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = {pool_reg, slot_reg};
                        mem_wdata   = 1'b0;
                        hint_we     = 1'b1;
                        new_hint    = slot_reg;
                        res_ok_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (!mem_rdata)
                begin
                    // Hinted slot is idle
                    mem_we        = 1'b1;
                    mem_waddr     = {pool_reg, cur_hint};
                    mem_wdata     = 1'b1;
                    hint_we       = 1'b1;
                    new_hint      = (cur_hint == LAST_IDX) ? '0 : cur_hint + 1'b1;
                    res_ok_next   = 1'b1;
                    res_slot_next = cur_hint;
                    state_next    = ST_DONE;
                end
                else
                begin
                    // Hint missed: search from slot 0
                    scan_next  = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = {pool_reg, {IDX_W{1'b0}}};
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (!mem_rdata)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = {pool_reg, scan_reg};
                    mem_wdata     = 1'b1;
                    hint_we       = 1'b1;
                    new_hint      = (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;
                    res_ok_next   = 1'b1;
                    res_slot_next = scan_reg;
                    state_next    = ST_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    // Pool full
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = {pool_reg, IDX_W'(scan_reg + 1'b1)};
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    granted_next   = SLOT_W'(res_slot_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hint updates go to the pool of the current item
    always_comb
    begin
        tex_hint_next = tex_hint_reg;
        shd_hint_next = shd_hint_reg;
        if (hint_we)
        begin
            if (pool_reg == POOL_SHD)
            begin
                shd_hint_next = new_hint;
            end
            else
            begin
                tex_hint_next = new_hint;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            scan_reg      <= '0;
            tex_hint_reg  <= '0;
            shd_hint_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_reg      <= scan_next;
            tex_hint_reg  <= tex_hint_next;
            shd_hint_reg  <= shd_hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pool_reg     <= pool_next;
        slot_reg     <= slot_next;
        range_reg    <= range_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        ok_reg       <= ok_next;
        granted_reg  <= granted_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign granted_slot = granted_reg;

endmodule

// ===== rtl/dpsa_busy_ram.sv =====
// Busy bitmap store for both pools: one write port, one read port,
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module dpsa_busy_ram #(
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [2**AW];
    logic rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dual pool slot allocator.
// Depends on dpsa_pkg and dual_pool_slot_allocator; drives items, predicts grants
// and compares every result against a local model of both pools or a hand-written expectation.
`timescale 1ns / 1ps

module testbench;

    import dpsa_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int NUM_PHASES   = 4;
    localparam int NUM_ROWS     = 16;
    localparam int LIMIT_CYCLES = 400000;

    // One expected result
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } grant_t;

    // One directed stimulus row; has_exp marks a hand-written expectation
    typedef struct packed {
        logic              cmd;
        logic              pl;
        logic [SLOT_W-1:0] s;
        logic              has_exp;
        logic              exp_ok;
        logic [SLOT_W-1:0] exp_slot;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              command;
    logic              pool;
    logic [SLOT_W-1:0] slot;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [SLOT_W-1:0] granted_slot;

    // Hand-written expectation travelling with the item on the input port
    logic              row_has_exp;
    logic              row_exp_ok;
    logic [SLOT_W-1:0] row_exp_slot;

    // Local copy of both pools, indexed by pool code
    logic [SLOTS-1:0]  busy_map [2] = '{default: '0};
    logic [SLOT_W-1:0] hint [2]     = '{default: '0};

    grant_t pending_grants [$];
    int     fail_count  = 0;
    int     cycle_count = 0;
    int     items_sent;
    int     idle_pct;
    int     stall_pct;

    row_t directed_rows [NUM_ROWS] = '{
        '{CMD_ALLOC, POOL_TEX, 6'd0,  1'b1, 1'b1, 6'd0},  // first grant after reset
        '{CMD_ALLOC, POOL_SHD, 6'd63, 1'b1, 1'b1, 6'd0},  // pools are independent
        '{CMD_ALLOC, POOL_TEX, 6'd0,  1'b1, 1'b1, 6'd1},
        '{CMD_FREE,  POOL_TEX, 6'd1,  1'b1, 1'b1, 6'd0},
        '{CMD_FREE,  POOL_TEX, 6'd1,  1'b1, 1'b0, 6'd0},  // free of an idle slot
        '{CMD_FREE,  POOL_SHD, 6'd63, 1'b1, 1'b0, 6'd0},
        '{CMD_ALLOC, POOL_TEX, 6'd42, 1'b0, 1'b0, 6'd0},  // hint points at freed slot
        '{CMD_FREE,  POOL_TEX, 6'd0,  1'b0, 1'b0, 6'd0},
        '{CMD_ALLOC, POOL_TEX, 6'd21, 1'b0, 1'b0, 6'd0},
        '{CMD_ALLOC, POOL_TEX, 6'd0,  1'b0, 1'b0, 6'd0},  // hint busy, search
        '{CMD_FREE,  POOL_SHD, 6'd0,  1'b0, 1'b0, 6'd0},
        '{CMD_FREE,  POOL_TEX, 6'd63, 1'b1, 1'b0, 6'd0},
        '{CMD_FREE,  POOL_SHD, 6'd42, 1'b1, 1'b0, 6'd0},
        '{CMD_FREE,  POOL_TEX, 6'd21, 1'b1, 1'b0, 6'd0},
        '{CMD_ALLOC, POOL_SHD, 6'd0,  1'b0, 1'b0, 6'd0},
        '{CMD_FREE,  POOL_TEX, 6'd2,  1'b0, 1'b0, 6'd0}
    };

    dual_pool_slot_allocator #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .pool(pool),
        .slot(slot),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .granted_slot(granted_slot)
    );

    // Grant prediction: updates the local pools and returns the result
    function automatic grant_t predict_grant(input logic c, input logic p,
                                             input logic [SLOT_W-1:0] s);
        grant_t g;
        int     h;
        g = '0;
        if (c == CMD_ALLOC) begin
            h = int'(hint[p]);
            if (h >= SLOTS)
                h = 0;
            if (busy_map[p][h]) begin
                // hint missed: lowest idle slot wins
                h = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (h < 0 && !busy_map[p][i])
                        h = i;
            end
            if (h >= 0) begin
                busy_map[p][h] = 1'b1;
                hint[p]        = (h == SLOTS - 1) ? '0 : SLOT_W'(h + 1);
                g.ok           = 1'b1;
                g.slot         = SLOT_W'(h);
            end
        end
        else if (int'(s) < SLOTS && busy_map[p][s]) begin
            busy_map[p][s] = 1'b0;
            hint[p]        = s;
            g.ok           = 1'b1;
        end
        return g;
    endfunction

    // Some busy slot of the pool, random when the pool is empty
    function automatic logic [SLOT_W-1:0] pick_busy_slot(input logic p);
        int start;
        int idx;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            idx = (start + k) % SLOTS;
            if (busy_map[p][idx])
                return SLOT_W'(idx);
        end
        return SLOT_W'($urandom_range(SLOTS - 1));
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stalls, changed at the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result check, then prediction of the item taken at this edge
    always @(posedge clk)
    begin
        grant_t exp_g;
        grant_t pred_g;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_grants.size() == 0) begin
                    $error("unexpected result: ok %0d granted_slot %0d", ok, granted_slot);
                    fail_count++;
                end
                else begin
                    exp_g = pending_grants.pop_front();
                    if (ok !== exp_g.ok) begin
                        $error("ok: expected %0d, actual %0d", exp_g.ok, ok);
                        fail_count++;
                    end
                    if (granted_slot !== exp_g.slot) begin
                        $error("granted_slot: expected %0d, actual %0d",
                               exp_g.slot, granted_slot);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                pred_g = predict_grant(command, pool, slot);
                if (row_has_exp)
                    pending_grants.push_back({row_exp_ok, row_exp_slot});
                else
                    pending_grants.push_back(pred_g);
            end
        end
    end

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic c, input logic p, input logic [SLOT_W-1:0] s,
                             input logic has_exp, input logic e_ok,
                             input logic [SLOT_W-1:0] e_slot);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid     <= 1'b1;
        command      <= c;
        pool         <= p;
        slot         <= s;
        row_has_exp  <= has_exp;
        row_exp_ok   <= e_ok;
        row_exp_slot <= e_slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_grants.size() != 0);
    endtask

    // Stimulus
    initial
    begin
        int  phase_end;
        int  sel;
        int  n;
        logic p;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_ALLOC;
        pool         = POOL_TEX;
        slot         = '0;
        row_has_exp  = 1'b0;
        row_exp_ok   = 1'b0;
        row_exp_slot = '0;
        items_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed rows
        for (int r = 0; r < NUM_ROWS; r++)
            send_item(directed_rows[r].cmd, directed_rows[r].pl, directed_rows[r].s,
                      directed_rows[r].has_exp, directed_rows[r].exp_ok,
                      directed_rows[r].exp_slot);
        drain_results();

        // random phases with different idle and stall mixes
        items_sent = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            phase_end = (ph + 1) * RANDOM_ITEMS / NUM_PHASES;

            // fill one pool past full, so full-pool requests and hint wrap occur
            if (ph == 0 || ph == 2) begin
                p = (ph == 0) ? POOL_TEX : POOL_SHD;
                n = SLOTS - $countones(busy_map[p]) + $urandom_range(1, 3);
                repeat (n)
                    send_item(CMD_ALLOC, p, SLOT_W'($urandom), 1'b0, 1'b0, '0);
            end

            while (items_sent < phase_end) begin
                sel = $urandom_range(99);
                p   = 1'($urandom_range(1));
                if (sel < 3) begin
                    // burst of frees of live slots
                    n = $urandom_range(4, 16);
                    repeat (n)
                        send_item(CMD_FREE, p, pick_busy_slot(p), 1'b0, 1'b0, '0);
                end
                else if (sel < 58)
                    send_item(CMD_ALLOC, p, SLOT_W'($urandom), 1'b0, 1'b0, '0);
                else if (sel < 85)
                    send_item(CMD_FREE, p, pick_busy_slot(p), 1'b0, 1'b0, '0);
                else
                    send_item(CMD_FREE, p, SLOT_W'($urandom), 1'b0, 1'b0, '0);
            end
            drain_results();
        end

        // tail: let any late result show up
        repeat (SLOTS + 8) @(posedge clk);
        if (pending_grants.size() != 0)
            $error("%0d results never arrived", pending_grants.size());
        if (fail_count == 0 && pending_grants.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
